[sv/isde_pkg.sv]
// Shared types and constants for the interleaved saturating delta encoder.
// No dependencies; imported by isde_slope and the top level.
package isde_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int RESIDUAL_W = 10;
    localparam int ACC_W      = 11;
    localparam int COUNT_W    = 5;

    typedef logic [SAMPLE_W-1:0]          sample_t;
    typedef logic signed [RESIDUAL_W-1:0] residual_t;
    typedef logic signed [ACC_W-1:0]      acc_t;
    typedef logic [COUNT_W-1:0]           count_t;

    // per-channel history
    typedef struct packed {
        sample_t   prev;
        residual_t res;
    } chan_state_t;

    localparam sample_t   PREV_RESET = 8'd128;
    localparam residual_t RES_RESET  = '0;
    localparam acc_t      SLOPE_MIN  = -11'sd128;
    localparam acc_t      SLOPE_MAX  = 11'sd127;
    localparam acc_t      RES_MIN    = -11'sd512;
    localparam acc_t      RES_MAX    = 11'sd511;
    localparam sample_t   CODE_BIAS  = 8'h80;

endpackage

[sv/isde_slope.sv]
// Per-sample slope coder: adds the new difference to the carried residual,
// clamps, and returns the offset code and the updated channel state.
// Depends on isde_pkg.
module isde_slope (
    input  isde_pkg::sample_t     sample,
    input  isde_pkg::chan_state_t state_in,
    output isde_pkg::sample_t     code,
    output isde_pkg::chan_state_t state_out
);
    import isde_pkg::*;

    acc_t acc;
    acc_t slope;
    acc_t rem;

    always_comb
    begin
        acc = acc_t'(state_in.res) + acc_t'({3'b000, sample})
            - acc_t'({3'b000, state_in.prev});

        if (acc < SLOPE_MIN)
            slope = SLOPE_MIN;
        else if (acc > SLOPE_MAX)
            slope = SLOPE_MAX;
        else
            slope = acc;

        rem = acc - slope;
        // never reached in practice, kept so the store cannot wrap
        if (rem < RES_MIN)
            rem = RES_MIN;
        else if (rem > RES_MAX)
            rem = RES_MAX;

        code            = slope[SAMPLE_W-1:0] ^ CODE_BIAS;
        state_out.prev  = sample;
        state_out.res   = rem[RESIDUAL_W-1:0];
    end

endmodule

[sv/interleaved_saturating_delta_encoder.sv]
// Interleaved saturating delta encoder: top level with channel counter,
// per-channel state memory, coding stage and output register. Uses isde_pkg
// and isde_slope. Samples pass the coding stage, then the output register,
// one per cycle while code_stall is low. State is read at acceptance, written
// back as the item leaves the coding stage, bypassed for a repeat channel.
// Reset (async, rst_n low): count 1, counter 0, all channels 128 / residual 0.
module interleaved_saturating_delta_encoder #(
    parameter int MAX_CHANNELS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    // sample channel
    input  logic              sample_valid,
    output logic              sample_stall,
    input  isde_pkg::sample_t sample,
    // code channel
    output logic              code_valid,
    input  logic              code_stall,
    output isde_pkg::sample_t code,
    // configuration: channel count
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  isde_pkg::count_t  channel_count
);
    import isde_pkg::*;

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

    // configuration register
    count_t             count_reg;
    logic [CNT_W-1:0]   eff_count;

    // channel counter
    logic [IDX_W-1:0]   chan_reg;
    logic [IDX_W-1:0]   chan_cur;
    logic [IDX_W-1:0]   chan_next;

    // handshakes
    logic               in_accept;
    logic               s1_move;

    // coding stage registers
    logic               s1_valid_reg;
    sample_t            s1_sample_reg;
    logic [IDX_W-1:0]   s1_chan_reg;
    logic               s1_fwd_reg;
    chan_state_t        s1_byp_reg;
    logic               s1_vld_reg;
    chan_state_t        mem_rd_reg;

    // channel state store; valid bits stand in for the reset values
    chan_state_t        state_mem [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] vld_reg;

    chan_state_t        s1_state;
    chan_state_t        new_state;
    sample_t            new_code;

    // output register
    logic               out_valid_reg;
    sample_t            code_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= count_t'(1);
        else if (cfg_valid && cfg_ready)
            count_reg <= channel_count;
    end

    // zero means one channel; above the build limit saturates
    always_comb
    begin
        if (count_reg == '0)
            eff_count = CNT_W'(1);
        else if (32'(count_reg) > MAX_CHANNELS)
            eff_count = CNT_W'(MAX_CHANNELS);
        else
            eff_count = CNT_W'(count_reg);
    end

    // a counter left past a lowered count restarts at channel zero
    always_comb
    begin
        if (32'(chan_reg) >= 32'(eff_count))
            chan_cur = '0;
        else
            chan_cur = chan_reg;

        if (32'(chan_cur) + 32'd1 >= 32'(eff_count))
            chan_next = '0;
        else
            chan_next = chan_cur + IDX_W'(1);
    end

    // flow control: output register, then one coding stage
    assign s1_move      = s1_valid_reg && (!out_valid_reg || !code_stall);
    assign sample_stall = s1_valid_reg && !s1_move;
    assign in_accept    = sample_valid && !sample_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            if (in_accept)
                chan_reg <= chan_next;

            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
                out_valid_reg <= 1'b1;
            else if (!code_stall)
                out_valid_reg <= 1'b0;

            if (s1_move)
                vld_reg[s1_chan_reg] <= 1'b1;
        end
    end

    // state store: write-back on leaving the coding stage, registered read
    always_ff @(posedge clk)
    begin
        if (s1_move)
            state_mem[s1_chan_reg] <= new_state;
        if (in_accept)
            mem_rd_reg <= state_mem[chan_cur];
    end

    // coding stage payload; a same-channel predecessor leaving this cycle
    // has not reached the store yet, so its new state is bypassed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_sample_reg <= sample;
            s1_chan_reg   <= chan_cur;
            s1_fwd_reg    <= s1_move && (s1_chan_reg == chan_cur);
            s1_byp_reg    <= new_state;
            s1_vld_reg    <= vld_reg[chan_cur];
        end
    end

    always_comb
    begin
        if (s1_fwd_reg)
            s1_state = s1_byp_reg;
        else if (s1_vld_reg)
            s1_state = mem_rd_reg;
        else
        begin
            s1_state.prev = PREV_RESET;
            s1_state.res  = RES_RESET;
        end
    end

    isde_slope u_slope (
        .sample    (s1_sample_reg),
        .state_in  (s1_state),
        .code      (new_code),
        .state_out (new_state)
    );

    always_ff @(posedge clk)
    begin
        if (s1_move)
            code_reg <= new_code;
    end

    assign code_valid = out_valid_reg;
    assign code       = code_reg;

    // residual stays within one sample swing either way
    a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (new_state.res >= -10'sd255 && new_state.res <= 10'sd255))
        else $error("residual out of range");

    // an accepted sample always lands in the coding stage
    a_accept_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted sample lost");

    // a held item in the coding stage keeps its channel
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> (s1_valid_reg && $stable(s1_chan_reg)))
        else $error("coding stage changed while held");

    // a coded item reaches the output register
    a_s1_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> code_valid)
        else $error("code not presented");

endmodule

[dv/tb.sv]
// Self-checking testbench for interleaved_saturating_delta_encoder.
// Depends on isde_pkg and the encoder RTL; builds a scoreboard class that
// tracks per-channel delta state and checks every code leaving the block.
module tb;

    import isde_pkg::*;

    localparam int MAX_CHANNELS  = 16;
    localparam int RANDOM_ITEMS  = 1830;
    localparam int HOLD_CYCLES   = 200;   // long output hold-off
    localparam int DRAIN_CYCLES  = 8;     // extra wait after the drain, for slack
    localparam int WATCHDOG_LIMIT = 2000; // cycles with no item moving anywhere

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the channel counter, last sample and carried
    // residual of every channel, and queues one code per accepted sample.
    // ------------------------------------------------------------------
    class delta_code_tracker;
        count_t      count_reg;
        sample_t     prior_sample [MAX_CHANNELS];
        int          carry       [MAX_CHANNELS];
        int unsigned chan;
        sample_t     pending_codes [$];
        int          errors;
        int          checked;
        int          clamped;

        function new();
            count_reg = count_t'(1);
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                prior_sample[i] = sample_t'(128);
                carry[i]        = 0;
            end
            chan    = 0;
            errors  = 0;
            checked = 0;
            clamped = 0;
        endfunction

        function void set_count(count_t value);
            count_reg = value;
        endfunction

        // zero counts as one channel, anything past the array saturates
        function int unsigned live_channels();
            if (count_reg == 0)
                return 1;
            if (count_reg > MAX_CHANNELS)
                return MAX_CHANNELS;
            return count_reg;
        endfunction

        // channel that the next accepted sample will be coded on
        function int unsigned next_channel();
            return (chan >= live_channels()) ? 0 : chan;
        endfunction

        function void take_sample(sample_t s);
            int unsigned n;
            int unsigned ch;
            int          acc;
            int          slope;
            n     = live_channels();
            ch    = next_channel();
            acc   = carry[ch] + int'(s) - int'(prior_sample[ch]);
            slope = acc;
            if (slope < -128)
                slope = -128;
            else if (slope > 127)
                slope = 127;
            if (slope != acc)
                clamped++;
            acc = acc - slope;
            if (acc < -512)
                acc = -512;
            else if (acc > 511)
                acc = 511;
            carry[ch]        = acc;
            prior_sample[ch] = s;
            pending_codes.push_back(sample_t'(slope + 128));
            chan = (ch + 1 >= n) ? 0 : ch + 1;
        endfunction

        function void match_code(sample_t actual);
            sample_t want;
            if (pending_codes.size() == 0)
            begin
                $display("%0t: unexpected code %0d with nothing pending", $time, actual);
                errors++;
                return;
            end
            want = pending_codes.pop_front();
            checked++;
            if (actual !== want)
            begin
                $display("%0t: code mismatch, expected %0d actual %0d", $time, want, actual);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and block ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic    clk;
    logic    rst_n         = 1'b0;
    logic    sample_valid  = 1'b0;
    logic    sample_stall;
    sample_t sample        = '0;
    logic    code_valid;
    logic    code_stall    = 1'b0;
    sample_t code;
    logic    cfg_valid     = 1'b0;
    logic    cfg_ready;
    count_t  channel_count = count_t'(1);

    // idling controls; tx is read only by the stimulus process
    bit tx_gaps  = 1'b1;
    bit rx_gaps  = 1'b0;
    bit hold_off = 1'b0;

    int settings_seen = 0;
    int watchdog      = 0;

    delta_code_tracker sb = new();

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    interleaved_saturating_delta_encoder #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .sample        (sample),
        .code_valid    (code_valid),
        .code_stall    (code_stall),
        .code          (code),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .channel_count (channel_count)
    );

    // ------------------------------------------------------------------
    // Receiver: random stalls plus an optional long hold-off. Only one
    // NBA to code_stall per edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
        code_stall <= hold_off || (rx_gaps && ($urandom_range(0, 99) < 12));

    // code monitor: values sampled here are the ones in force before the edge
    always @(posedge clk)
        if (rst_n && code_valid && !code_stall)
            sb.match_code(code);

    // watchdog: any item moving on any channel restarts the count
    always @(posedge clk)
    begin
        if (rst_n && ((sample_valid && !sample_stall) || (code_valid && !code_stall)
                      || (cfg_valid && cfg_ready)))
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
        if (watchdog >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles, %0d codes still pending",
                     $time, watchdog, sb.pending_codes.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender side. Each task returns at a rising edge.
    // ------------------------------------------------------------------

    // Offer one sample until it is taken; valid stays high between
    // back-to-back items and is only dropped for a gap.
    task automatic send(input sample_t s);
        sample_valid <= 1'b1;
        sample       <= s;
        do
            @(posedge clk);
        while (sample_stall);
        sb.take_sample(s);
        if (tx_gaps && ($urandom_range(0, 99) < 12))
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Stop offering and wait for every code in flight to come out.
    task automatic drain();
        sample_valid <= 1'b0;
        while (sb.pending_codes.size() != 0)
            @(posedge clk);
    endtask

    // Channel count write; only called with the block drained.
    task automatic write_count(input count_t value);
        cfg_valid     <= 1'b1;
        channel_count <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_count(value);
        settings_seen++;
    endtask

    // Random sample: small steps from the channel's last value 40% of the time,
    // with uniform, full-scale and large jumps mixed in.
    function automatic sample_t pick_sample();
        int unsigned ch;
        int          base;
        int          v;
        int unsigned r;
        ch   = sb.next_channel();
        base = int'(sb.prior_sample[ch]);
        r    = $urandom_range(0, 99);
        if (r < 40)
            v = base + int'($urandom_range(0, 16)) - 8;
        else if (r < 65)
            v = int'($urandom_range(0, 255));
        else if (r < 80)
            v = $urandom_range(0, 1) ? 255 : 0;
        else
            v = $urandom_range(0, 1) ? base + int'($urandom_range(100, 255))
                                     : base - int'($urandom_range(100, 255));
        if (v < 0)
            v = 0;
        else if (v > 255)
            v = 255;
        return sample_t'(v);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int     sent;
        int     phase;
        int     burst;
        count_t next_count;
        count_t fixed_counts [9];

        fixed_counts = '{16, 1, 31, 0, 17, 2, 8, 15, 5};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, default single channel: full-scale swings saturate the
        // slope and leave a residual that the following codes pay back.
        send(8'd255);
        send(8'd0);
        send(8'd0);
        send(8'd0);
        send(8'd255);
        send(8'd255);
        send(8'd128);
        send(8'd127);

        // count zero behaves as one channel
        drain();
        write_count(count_t'(0));
        send(8'd1);
        send(8'd254);

        // count past the array saturates to all channels; fresh channels
        // start from the mid-scale history
        drain();
        write_count(count_t'(31));
        send(8'd0);
        send(8'd255);
        send(8'd255);
        send(8'd0);

        // counter sits at 4, count drops to 3: coding restarts at channel 0
        drain();
        write_count(count_t'(3));
        send(8'd255);
        send(8'd0);
        send(8'd200);

        // Random phases, each under its own channel count. Phases 2 and 3
        // run without any idling; phase 5 holds the output off for a long
        // stretch while samples keep coming, so the block backs up.
        sent  = 0;
        phase = 0;
        rx_gaps <= 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            next_count = (phase < 9) ? fixed_counts[phase]
                                     : count_t'($urandom_range(0, 31));
            drain();
            write_count(next_count);
            tx_gaps = !(phase == 2 || phase == 3);
            rx_gaps <= !(phase == 2 || phase == 3);
            burst = (phase == 2) ? 200 : int'($urandom_range(40, 160));
            if (phase == 5)
            begin
                burst = 120;
                fork
                    begin
                        hold_off <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge clk);
                        hold_off <= 1'b0;
                    end
                join_none
            end
            for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++)
            begin
                send(pick_sample());
                sent++;
            end
            phase++;
        end

        // Drain, then keep watching for stray codes before the final check.
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending_codes.size() != 0)
        begin
            $display("%0t: %0d codes never arrived", $time, sb.pending_codes.size());
            sb.errors++;
        end

        $display("tb: %0d codes checked across %0d channel-count writes (%0d phases)",
                 sb.checked, settings_seen, phase);
        $display("tb: %0d slopes saturated, one %0d-cycle output hold-off, %0d errors",
                 sb.clamped, HOLD_CYCLES, sb.errors);
        if (sb.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
